@@ sv/pps_pkg.sv @@
// Shared field widths and opcode codes for the preemptive priority scheduler.
`timescale 1ns / 1ps

package pps_pkg;

  // Fixed widths of the request and result fields
  localparam int unsigned OPCODE_W   = 2;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned IN_TIME_W  = 16;
  localparam int unsigned PRIO_W     = 8;
  localparam int unsigned OUT_TIME_W = 16;

  // Request opcodes
  typedef enum logic [OPCODE_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

endpackage

@@ sv/pps_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module pps_ram #(
  parameter int unsigned WIDTH = 56,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry, register the read data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/preemptive_priority_scheduler.sv @@
// Top level of the preemptive priority scheduler: task table, slot scan and result logic.
`timescale 1ns / 1ps

// A request is taken at a rising edge with start high and busy low. Clear and
// load requests never raise busy; their result strobes in the next cycle. A
// tick request raises busy while the task table, kept in one RAM with a
// registered read, is scanned one slot per cycle; then an update state
// decrements the chosen task and writes it back. The result strobes on
// result_valid_o for a single cycle right after busy falls, and the receiver
// cannot stall it. all_done_o follows the task marks at all times and is valid
// whenever result_valid_o is high. No clearing pass is needed after reset.
module preemptive_priority_scheduler #(
  parameter int unsigned TASK_SLOTS = 16,
  parameter int unsigned TIME_BITS  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [pps_pkg::OPCODE_W-1:0]      opcode_i,
  input  logic [pps_pkg::SLOT_W-1:0]        slot_i,
  input  logic [pps_pkg::IN_TIME_W-1:0]     arrival_time_i,
  input  logic [pps_pkg::IN_TIME_W-1:0]     burst_length_i,
  input  logic [pps_pkg::PRIO_W-1:0]        task_priority_i,
  output logic                              result_valid_o,
  output logic                              ran_o,
  output logic [pps_pkg::SLOT_W-1:0]        running_slot_o,
  output logic [pps_pkg::OUT_TIME_W-1:0]    tick_start_o,
  output logic                              finished_o,
  output logic [pps_pkg::OUT_TIME_W-1:0]    completion_time_o,
  output logic [pps_pkg::OUT_TIME_W-1:0]    turnaround_time_o,
  output logic [pps_pkg::OUT_TIME_W-1:0]    waiting_time_o,
  output logic                              all_done_o
);

  import pps_pkg::*;

  localparam int unsigned SLOT_BITS = $clog2(TASK_SLOTS);
  localparam int unsigned CNT_W     = SLOT_BITS + 1;
  localparam int unsigned ENT_W     = 3 * TIME_BITS + PRIO_W;
  localparam int unsigned PRI_LO    = 0;
  localparam int unsigned REM_LO    = PRIO_W;
  localparam int unsigned BUR_LO    = PRIO_W + TIME_BITS;
  localparam int unsigned ARR_LO    = PRIO_W + 2 * TIME_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

  state_e                 state_q;
  logic [CNT_W-1:0]       cnt_q;
  logic                   chk_vld_q;
  logic [SLOT_BITS-1:0]   chk_idx_q;
  logic                   found_q;
  logic [TASK_SLOTS-1:0]  loaded_q;
  logic [TASK_SLOTS-1:0]  finished_q;
  logic [TIME_BITS-1:0]   time_q;
  logic [TIME_BITS-1:0]   tinc_q;

  // Best candidate so far
  logic [SLOT_BITS-1:0]   best_idx_q;
  logic [PRIO_W-1:0]      best_pri_q;
  logic [TIME_BITS-1:0]   best_arr_q;
  logic [TIME_BITS-1:0]   best_bur_q;
  logic [TIME_BITS-1:0]   best_rem_q;
  logic [TIME_BITS-1:0]   best_sum_q;

  // Result registers
  logic                   result_valid_q;
  logic                   ran_q;
  logic [SLOT_W-1:0]      slot_q;
  logic [OUT_TIME_W-1:0]  tick_start_q;
  logic                   fin_q;
  logic [OUT_TIME_W-1:0]  comp_q;
  logic [OUT_TIME_W-1:0]  tat_q;
  logic [OUT_TIME_W-1:0]  wt_q;

  // Request decode
  logic                   accept;
  logic                   slot_in_range;
  logic [SLOT_BITS-1:0]   slot_idx;
  logic [TIME_BITS-1:0]   in_arr;
  logic [TIME_BITS-1:0]   in_bur;

  assign busy          = (state_q != ST_IDLE);
  assign accept        = start && !busy;
  assign slot_in_range = (32'(slot_i) < TASK_SLOTS);
  assign slot_idx      = SLOT_BITS'(slot_i);
  assign in_arr        = TIME_BITS'(arrival_time_i);
  assign in_bur        = TIME_BITS'(burst_length_i);

  // RAM ports
  logic                   ram_we;
  logic [SLOT_BITS-1:0]   ram_waddr;
  logic [ENT_W-1:0]       ram_wdata;
  logic                   ram_re;
  logic [ENT_W-1:0]       ram_rdata;

  logic                   scan_issue;
  logic                   load_write;
  logic                   tick_write;

  assign scan_issue = (state_q == ST_SCAN) && (cnt_q != CNT_W'(TASK_SLOTS));
  assign load_write = accept && (opcode_i == OP_LOAD) && slot_in_range;
  assign tick_write = (state_q == ST_UPDATE) && found_q;
  assign ram_re     = scan_issue;

  // Decrement and times of the chosen task
  logic [TIME_BITS-1:0]   rem_new;
  logic                   fin_now;
  logic [TIME_BITS-1:0]   tat_now;
  logic [TIME_BITS-1:0]   wt_now;

  assign rem_new = best_rem_q - TIME_BITS'(1);
  assign fin_now = found_q && (rem_new == '0);
  assign tat_now = tinc_q - best_arr_q;
  assign wt_now  = tinc_q - best_sum_q;

  // Select write source: load request or tick writeback
  always_comb begin
    if (tick_write) begin
      ram_we    = 1'b1;
      ram_waddr = best_idx_q;
      ram_wdata = {best_arr_q, best_bur_q, rem_new, best_pri_q};
    end else begin
      ram_we    = load_write;
      ram_waddr = slot_idx;
      ram_wdata = {in_arr, in_bur, in_bur, task_priority_i};
    end
  end

  pps_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TASK_SLOTS)
  ) u_task_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (cnt_q[SLOT_BITS-1:0]),
    .rdata_o (ram_rdata)
  );

  // Compare the slot read back against the best so far
  logic [TIME_BITS-1:0]   rd_arr;
  logic [TIME_BITS-1:0]   rd_bur;
  logic [TIME_BITS-1:0]   rd_rem;
  logic [PRIO_W-1:0]      rd_pri;
  logic                   cand;
  logic                   take;
  logic                   scan_last;

  assign rd_arr    = ram_rdata[ARR_LO +: TIME_BITS];
  assign rd_bur    = ram_rdata[BUR_LO +: TIME_BITS];
  assign rd_rem    = ram_rdata[REM_LO +: TIME_BITS];
  assign rd_pri    = ram_rdata[PRI_LO +: PRIO_W];
  assign cand      = loaded_q[chk_idx_q] && !finished_q[chk_idx_q] && (rd_arr <= time_q);
  assign take      = chk_vld_q && cand && (!found_q || (rd_pri < best_pri_q));
  assign scan_last = chk_vld_q && (chk_idx_q == SLOT_BITS'(TASK_SLOTS - 1));

  // Control state, marks, time and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      cnt_q          <= '0;
      chk_vld_q      <= 1'b0;
      found_q        <= 1'b0;
      loaded_q       <= '0;
      finished_q     <= '0;
      time_q         <= '0;
      result_valid_q <= 1'b0;
      ran_q          <= 1'b0;
      slot_q         <= '0;
      tick_start_q   <= '0;
      fin_q          <= 1'b0;
      comp_q         <= '0;
      tat_q          <= '0;
      wt_q           <= '0;
    end else begin
      result_valid_q <= 1'b0;
      chk_vld_q      <= scan_issue;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            ran_q        <= 1'b0;
            slot_q       <= '0;
            tick_start_q <= '0;
            fin_q        <= 1'b0;
            comp_q       <= '0;
            tat_q        <= '0;
            wt_q         <= '0;
            unique case (opcode_i)
              OP_CLEAR: begin
                loaded_q       <= '0;
                finished_q     <= '0;
                time_q         <= '0;
                result_valid_q <= 1'b1;
              end
              OP_LOAD: begin
                if (slot_in_range) begin
                  loaded_q[slot_idx]   <= 1'b1;
                  finished_q[slot_idx] <= (in_bur == '0);
                end
                result_valid_q <= 1'b1;
              end
              OP_TICK: begin
                state_q <= ST_SCAN;
                cnt_q   <= '0;
                found_q <= 1'b0;
              end
              default: begin
                result_valid_q <= 1'b1;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (scan_issue) begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
          if (take) begin
            found_q <= 1'b1;
          end
          if (scan_last) begin
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          time_q         <= tinc_q;
          if (fin_now) begin
            finished_q[best_idx_q] <= 1'b1;
          end
          ran_q          <= found_q;
          slot_q         <= found_q ? SLOT_W'(best_idx_q) : '0;
          tick_start_q   <= OUT_TIME_W'(time_q);
          fin_q          <= fin_now;
          comp_q         <= fin_now ? OUT_TIME_W'(tinc_q) : '0;
          tat_q          <= fin_now ? OUT_TIME_W'(tat_now) : '0;
          wt_q           <= fin_now ? OUT_TIME_W'(wt_now) : '0;
          result_valid_q <= 1'b1;
          state_q        <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Hold scan index, next time and best candidate payload
  always_ff @(posedge clk_i) begin
    chk_idx_q <= cnt_q[SLOT_BITS-1:0];
    if (accept && (opcode_i == OP_TICK)) begin
      tinc_q <= time_q + TIME_BITS'(1);
    end
    if (take) begin
      best_idx_q <= chk_idx_q;
      best_pri_q <= rd_pri;
      best_arr_q <= rd_arr;
      best_bur_q <= rd_bur;
      best_rem_q <= rd_rem;
      best_sum_q <= rd_arr + rd_bur;
    end
  end

  assign result_valid_o    = result_valid_q;
  assign ran_o             = ran_q;
  assign running_slot_o    = slot_q;
  assign tick_start_o      = tick_start_q;
  assign finished_o        = fin_q;
  assign completion_time_o = comp_q;
  assign turnaround_time_o = tat_q;
  assign waiting_time_o    = wt_q;
  assign all_done_o        = ~|(loaded_q & ~finished_q);

  // A finishing report always comes with a task that ran
  a_fin_ran : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && finished_o) |-> ran_o)
    else $error("finished reported without a running task");

  // A tick request enters the scan
  a_tick_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (opcode_i == OP_TICK)) |=> busy)
    else $error("tick request did not start a scan");

  // The update cycle always delivers a result
  a_update_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE) |=> (result_valid_o && !busy))
    else $error("tick result missing after update");

  // The task that ran must be a loaded slot
  a_ran_loaded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && ran_o) |-> loaded_q[best_idx_q])
    else $error("reported slot is not loaded");

endmodule
